// File: sv/tspp_pkg.sv
// ----------------------------------------------------------------------------
// tspp_pkg
// Shared constants and types for the transport stream packet parser.
// ----------------------------------------------------------------------------
package tspp_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int COUNT_W      = 8;

  localparam logic [7:0] SYNC_MARK        = 8'h47;
  localparam int         FIELD_LEN_POS    = 4;
  localparam int         FIELD_FLAGS_POS  = 5;
  localparam int         PCR_FIRST_POS    = 6;
  localparam int         PCR_LAST_POS     = 11;
  localparam int         PCR_END_COUNT    = PCR_LAST_POS + 1;
  localparam int         PCR_MIN_LENGTH   = 7;
  localparam int         PCR_FLAG_BIT     = 4;
  localparam int         MAX_FIELD_LENGTH = PACKET_BYTES - 5;
  localparam int         LAST_POS         = PACKET_BYTES - 1;
  localparam int         PCR_SCALE        = 300;
  localparam int         PCR_W            = 42;

  localparam logic [1:0] MODE_PAYLOAD     = 2'd1;
  localparam logic [1:0] MODE_BOTH        = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SYNC = 2'd1,
    STATUS_LENGTH   = 2'd2,
    STATUS_SHORT    = 2'd3
  } status_t;

endpackage

// File: sv/ts_packet_parser_core.sv
// ----------------------------------------------------------------------------
// ts_packet_parser_core
// Byte-wide transport stream packet parser with header, PCR and payload output.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per beat (data_byte) with packet_start marking
// byte 0 of a packet; without a start mark packets are framed by counting
// 188 bytes. Output channel: at most one result per input beat, either a
// payload byte (out_kind 0) or an end-of-packet summary (out_kind 1) with the
// header fields, PCR and status.
// A result is held in the output register from the cycle after the input
// beat that causes it. Throughput: one input beat per cycle unless stalled,
// set by the single output register; the PCR product (33 by 9 bits) is the longest path.
// A summary is given at the last byte of a packet, or with status short when
// packet_start arrives before the packet is complete.
// Reset clears the byte counter, all packet state and the output valid flag.
// When the receiver stalls, in_ready drops only while a result is held and
// out_ready is low; the held result stays stable until taken.
// ----------------------------------------------------------------------------
module ts_packet_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  payload_byte,
  output logic [12:0] pid,
  output logic        payload_unit_start,
  output logic        transport_error,
  output logic        priority_bit,
  output logic [1:0]  scrambling,
  output logic [1:0]  adaptation_mode,
  output logic [3:0]  continuity,
  output logic        has_pcr,
  output logic [41:0] pcr_value,
  output logic [1:0]  status
);

  logic [tspp_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [23:0]                  header_bytes, header_bytes_next;
  logic [7:0]                   field_length, field_length_next;
  logic [7:0]                   field_flags, field_flags_next;
  logic [47:0]                  clock_ref_shift, clock_ref_shift_next;
  tspp_pkg::status_t            packet_status, packet_status_next;
  logic                         payload_enabled, payload_enabled_next;

  logic                         accept;
  logic                         short_end;
  logic                         last_byte;
  logic                         payload_now;
  logic                         emit;
  logic [tspp_pkg::COUNT_W-1:0] pos;
  logic [1:0]                   mode;
  logic                         pcr_base_ok;
  logic                         received_ok;
  logic                         res_kind;
  logic [7:0]                   res_byte;
  tspp_pkg::status_t            res_status;
  logic [tspp_pkg::PCR_W-1:0]   pcr_calc;
  logic [tspp_pkg::COUNT_W:0]   payload_pos;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign short_end = packet_start && (byte_count != '0);
  assign pos       = short_end ? '0 : byte_count;
  assign last_byte = (pos == tspp_pkg::COUNT_W'(tspp_pkg::LAST_POS));
  assign mode      = header_bytes[5:4];

  // packet state update for this beat
  always_comb begin
    header_bytes_next    = header_bytes;
    field_length_next    = field_length;
    field_flags_next     = field_flags;
    clock_ref_shift_next = clock_ref_shift;
    packet_status_next   = packet_status;
    payload_enabled_next = payload_enabled;
    payload_now          = payload_enabled && (packet_status == tspp_pkg::STATUS_OK);
    payload_pos          = '0;
    if (pos == '0) begin
      header_bytes_next    = '0;
      field_length_next    = '0;
      field_flags_next     = '0;
      clock_ref_shift_next = '0;
      payload_enabled_next = 1'b0;
      payload_now          = 1'b0;
      packet_status_next   = (data_byte != tspp_pkg::SYNC_MARK) ?
                             tspp_pkg::STATUS_BAD_SYNC : tspp_pkg::STATUS_OK;
    end else if (pos <= tspp_pkg::COUNT_W'(3)) begin
      header_bytes_next = {header_bytes[15:0], data_byte};
      if (pos == tspp_pkg::COUNT_W'(3)) begin
        payload_enabled_next = (packet_status == tspp_pkg::STATUS_OK) &&
                               (data_byte[5:4] == tspp_pkg::MODE_PAYLOAD);
      end
    end else if (mode[1]) begin
      if (pos == tspp_pkg::COUNT_W'(tspp_pkg::FIELD_LEN_POS)) begin
        field_length_next = data_byte;
        if ((packet_status == tspp_pkg::STATUS_OK) &&
            (data_byte > 8'(tspp_pkg::MAX_FIELD_LENGTH))) begin
          packet_status_next = tspp_pkg::STATUS_LENGTH;
        end
      end else if ((pos == tspp_pkg::COUNT_W'(tspp_pkg::FIELD_FLAGS_POS)) &&
                   (field_length != '0)) begin
        field_flags_next = data_byte;
      end else if ((pos >= tspp_pkg::COUNT_W'(tspp_pkg::PCR_FIRST_POS)) &&
                   (pos <= tspp_pkg::COUNT_W'(tspp_pkg::PCR_LAST_POS))) begin
        clock_ref_shift_next = {clock_ref_shift[39:0], data_byte};
      end
      payload_pos = (tspp_pkg::COUNT_W+1)'(tspp_pkg::FIELD_LEN_POS) +
                    {1'b0, field_length_next};
      if ((mode == tspp_pkg::MODE_BOTH) &&
          (packet_status_next == tspp_pkg::STATUS_OK) &&
          ({1'b0, pos} == payload_pos)) begin
        payload_enabled_next = 1'b1;
      end
    end
    byte_count_next = last_byte ? '0 : pos + tspp_pkg::COUNT_W'(1);
  end

  // result selection
  always_comb begin
    res_kind    = tspp_pkg::KIND_PAYLOAD;
    res_byte    = data_byte;
    res_status  = tspp_pkg::STATUS_OK;
    received_ok = (pos >= tspp_pkg::COUNT_W'(tspp_pkg::PCR_LAST_POS));
    if (short_end) begin
      res_kind    = tspp_pkg::KIND_SUMMARY;
      res_byte    = '0;
      res_status  = tspp_pkg::STATUS_SHORT;
      received_ok = (byte_count >= tspp_pkg::COUNT_W'(tspp_pkg::PCR_END_COUNT));
    end else if (last_byte) begin
      res_kind    = tspp_pkg::KIND_SUMMARY;
      res_byte    = payload_now ? data_byte : '0;
      res_status  = packet_status_next;
      received_ok = 1'b1;
    end
  end

  assign emit = short_end || last_byte || payload_now;

  assign pcr_base_ok = mode[1] && (packet_status == tspp_pkg::STATUS_OK) &&
                       (field_length >= 8'(tspp_pkg::PCR_MIN_LENGTH)) &&
                       field_flags[tspp_pkg::PCR_FLAG_BIT];

  // base is the top 33 bits, extension the low 9 bits
  assign pcr_calc = tspp_pkg::PCR_W'(clock_ref_shift[47:15]) *
                    tspp_pkg::PCR_W'(tspp_pkg::PCR_SCALE) +
                    tspp_pkg::PCR_W'(clock_ref_shift[8:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      header_bytes    <= '0;
      field_length    <= '0;
      field_flags     <= '0;
      clock_ref_shift <= '0;
      packet_status   <= tspp_pkg::STATUS_OK;
      payload_enabled <= 1'b0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      header_bytes    <= header_bytes_next;
      field_length    <= field_length_next;
      field_flags     <= field_flags_next;
      clock_ref_shift <= clock_ref_shift_next;
      packet_status   <= packet_status_next;
      payload_enabled <= payload_enabled_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind           <= res_kind;
      payload_byte       <= res_byte;
      pid                <= header_bytes[20:8];
      payload_unit_start <= header_bytes[22];
      transport_error    <= header_bytes[23];
      priority_bit       <= header_bytes[21];
      scrambling         <= header_bytes[7:6];
      adaptation_mode    <= mode;
      continuity         <= header_bytes[3:0];
      has_pcr            <= pcr_base_ok && received_ok;
      pcr_value          <= (pcr_base_ok && received_ok) ? pcr_calc : '0;
      status             <= res_status;
    end
  end

endmodule

// File: sv/tspp_checker.sv
// ----------------------------------------------------------------------------
// tspp_checker
// Port-level checks for the transport stream packet parser, bound to the top.
// ----------------------------------------------------------------------------
module tspp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        packet_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  payload_byte,
  input logic [12:0] pid,
  input logic        payload_unit_start,
  input logic        transport_error,
  input logic        priority_bit,
  input logic [1:0]  scrambling,
  input logic [1:0]  adaptation_mode,
  input logic [3:0]  continuity,
  input logic        has_pcr,
  input logic [41:0] pcr_value,
  input logic [1:0]  status
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(payload_byte) && $stable(pcr_value) && $stable(status))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // payload beats come only from good packets with a payload
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == tspp_pkg::KIND_PAYLOAD) |->
    (status == tspp_pkg::STATUS_OK) &&
    ((adaptation_mode == tspp_pkg::MODE_PAYLOAD) ||
     (adaptation_mode == tspp_pkg::MODE_BOTH)))
    else $error("payload beat from a packet without valid payload");

  a_pcr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_pcr |-> (pcr_value == '0))
    else $error("pcr value without pcr");

  a_pcr_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_pcr |-> adaptation_mode[1] &&
    ((status == tspp_pkg::STATUS_OK) || (status == tspp_pkg::STATUS_SHORT)))
    else $error("pcr reported without adaptation field");

endmodule

bind ts_packet_parser_core tspp_checker u_tspp_checker (.*);
